>>> sv/msup_pkg.sv
// ----------------------------------------------------------------------------
// msup_pkg
// Shared types, sizes and constants of the motor speed supervisor.
// ----------------------------------------------------------------------------
package msup_pkg;

  localparam int WINDOW_SLOTS  = 10;
  localparam int PENDING_DEPTH = 10;

  localparam int WIDX_W  = $clog2(WINDOW_SLOTS);
  localparam int WFILL_W = $clog2(WINDOW_SLOTS + 1);
  localparam int WSUM_W  = $clog2(WINDOW_SLOTS * 65535 + 1);
  localparam int PIDX_W  = $clog2(PENDING_DEPTH);
  localparam int ADDR_W  = 5;

  localparam logic [2:0] REG_TICK_MS      = 3'd0;
  localparam logic [2:0] REG_OVER_IVL     = 3'd1;
  localparam logic [2:0] REG_UNDER_IVL    = 3'd2;
  localparam logic [2:0] REG_UNDER_DELAY  = 3'd3;
  localparam logic [2:0] REG_NO_PULSE     = 3'd4;

  localparam logic [6:0]  RST_TICK_MS     = 7'd5;
  localparam logic [15:0] RST_OVER_IVL    = 16'd1000;
  localparam logic [16:0] RST_UNDER_IVL   = 17'd10000;
  localparam logic [16:0] RST_UNDER_DELAY = 17'd5000;
  localparam logic [9:0]  RST_NO_PULSE    = 10'd100;

  localparam logic       KIND_TICK  = 1'b0;
  localparam logic       KIND_PULSE = 1'b1;
  localparam logic [1:0] ESC_RUN    = 2'd0;
  localparam logic [1:0] ESC_STOP   = 2'd1;
  localparam logic [1:0] ESC_OTHER  = 2'd2;

  localparam logic [15:0] PULSE_MAX  = 16'hFFFF;
  localparam logic [14:0] RUN_MAX    = 15'd20000;
  localparam logic [13:0] TMO_MAX    = 14'd10000;
  localparam logic [7:0]  SILENT_MAX = 8'd200;
  localparam logic [7:0]  CNT_MAX    = 8'd255;
  localparam logic [7:0]  BAD_LIMIT  = 8'd5;
  localparam logic [7:0]  GOOD_LIMIT = 8'd10;
  localparam logic [20:0] TMO_MS     = 21'd8000;
  localparam logic [14:0] SLOT_MS    = 15'd100;

  typedef struct packed {
    logic        kind;
    logic [1:0]  esc_state;
    logic [15:0] capture_time;
  } item_t;

  typedef struct packed {
    logic [15:0] speed_pulses;
    logic        overspeed_fault;
    logic        underspeed_fault;
    logic        timeout_fault;
    logic        stop_done;
  } result_t;

  typedef struct packed {
    logic [6:0]  tick_ms;
    logic [15:0] overspeed_interval;
    logic [16:0] underspeed_interval;
    logic [16:0] underspeed_delay_ms;
    logic [9:0]  no_pulse_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic bump;
    logic step;
  } win_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WIN,
    ST_WSUM,
    ST_PREAD,
    ST_PJUDGE,
    ST_DONE
  } state_t;

endpackage

>>> sv/msup_window.sv
// ----------------------------------------------------------------------------
// msup_window
// Pulse count of the open slot and circular memory of closed 100 ms slots,
// with a running sum that gives the speed.
// ----------------------------------------------------------------------------
module msup_window (
  input  logic               clk,
  input  logic               rst,
  input  logic [6:0]         tick_ms,
  input  msup_pkg::win_cmd_t cmd,
  output logic [15:0]        speed
);

  logic [15:0] win_mem [msup_pkg::WINDOW_SLOTS];
  logic [15:0] oldest_q;
  logic [15:0] oldest;
  logic [15:0] slot_pulses;
  logic [7:0]  slot_ticks;
  logic [7:0]  slot_inc;
  logic [14:0] slot_prod;
  logic        slot_close;
  logic        shifting;
  logic [msup_pkg::WIDX_W-1:0]  head;
  logic [msup_pkg::WIDX_W-1:0]  head_next;
  logic [msup_pkg::WFILL_W-1:0] fill;
  logic [msup_pkg::WSUM_W-1:0]  sum;
  logic [msup_pkg::WSUM_W-1:0]  sum_next;

  always_comb begin
    slot_inc   = slot_ticks + 8'd1;
    slot_prod  = {7'd0, slot_inc} * {8'd0, tick_ms};
    slot_close = slot_prod >= msup_pkg::SLOT_MS;
    oldest     = (fill == msup_pkg::WFILL_W'(msup_pkg::WINDOW_SLOTS)) ? oldest_q : 16'd0;
    sum_next   = sum - msup_pkg::WSUM_W'(oldest) + msup_pkg::WSUM_W'(slot_pulses);
    head_next  = (head == msup_pkg::WIDX_W'(msup_pkg::WINDOW_SLOTS - 1)) ? '0
                                                                          : head + 1'b1;
    speed      = (sum > msup_pkg::WSUM_W'(msup_pkg::PULSE_MAX)) ? msup_pkg::PULSE_MAX
                                                                 : sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks  <= 8'd0;
      slot_pulses <= 16'd0;
      head        <= '0;
      fill        <= '0;
      sum         <= '0;
      shifting    <= 1'b0;
    end else begin
      shifting <= cmd.step && slot_close;
      if (cmd.step) begin
        slot_ticks <= slot_close ? 8'd0 : slot_inc;
      end
      if (shifting) begin
        head        <= head_next;
        sum         <= sum_next;
        slot_pulses <= 16'd0;
        if (fill != msup_pkg::WFILL_W'(msup_pkg::WINDOW_SLOTS)) begin
          fill <= fill + 1'b1;
        end
      end else if (cmd.bump && slot_pulses != msup_pkg::PULSE_MAX) begin
        slot_pulses <= slot_pulses + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      oldest_q <= win_mem[head];
    end
    if (shifting) begin
      win_mem[head] <= slot_pulses;
    end
  end

endmodule

>>> sv/msup_ctrl.sv
// ----------------------------------------------------------------------------
// msup_ctrl
// Sequencer of the supervisor: pending interval memory, fault counters,
// state-entry handling and the result register.
// ----------------------------------------------------------------------------
module msup_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  msup_pkg::cfg_t     cfg,
  input  msup_pkg::item_t    item,
  input  logic               item_valid,
  output logic               item_ready,
  output msup_pkg::result_t  result,
  output logic               result_valid,
  input  logic               result_ready,
  output msup_pkg::win_cmd_t win_cmd,
  input  logic [15:0]        speed
);

  msup_pkg::state_t  state;
  msup_pkg::state_t  state_next;
  msup_pkg::result_t res;

  logic [16:0] pend_mem [msup_pkg::PENDING_DEPTH];
  logic [16:0] rd_data;
  logic [16:0] interval;
  logic [msup_pkg::PIDX_W-1:0] pcount;
  logic [msup_pkg::PIDX_W-1:0] idx;
  logic [msup_pkg::PIDX_W-1:0] idx_inc;
  logic [msup_pkg::PIDX_W-1:0] raddr;

  logic [1:0]  st;
  logic [1:0]  st_in;
  logic [1:0]  prev_st;
  logic [15:0] last_cap;
  logic [14:0] running;
  logic [14:0] running_base;
  logic [14:0] running_new;
  logic [13:0] timeout;
  logic [13:0] timeout_base;
  logic [13:0] timeout_new;
  logic [7:0]  silent;
  logic [7:0]  silent_inc;
  logic [7:0]  good;
  logic [7:0]  bad;
  logic [7:0]  good_inc;
  logic [7:0]  bad_inc;
  logic [7:0]  good_j;
  logic [7:0]  bad_j;
  logic [20:0] tmo_prod;
  logic [21:0] run_prod;
  logic [14:0] sil_prod;

  logic stopped;
  logic stopped_final;
  logic adv;
  logic tmo_chk;
  logic run_late;
  logic sil_late;
  logic over;
  logic under;
  logic run_entry;
  logic stop_entry;
  logic tick_take;
  logic pulse_take;
  logic res_load;
  logic res_valid;
  logic pend_any;
  logic is_bad;
  logic over_hit;
  logic under_hit;

  always_comb begin
    st_in        = (item.esc_state inside {msup_pkg::ESC_RUN, msup_pkg::ESC_STOP})
                   ? item.esc_state : msup_pkg::ESC_OTHER;
    tick_take    = item_valid && item_ready && item.kind == msup_pkg::KIND_TICK;
    pulse_take   = item_valid && item_ready && item.kind == msup_pkg::KIND_PULSE &&
                   st_in != msup_pkg::ESC_OTHER;
    run_entry    = st_in == msup_pkg::ESC_RUN && prev_st != msup_pkg::ESC_RUN;
    stop_entry   = st_in == msup_pkg::ESC_STOP && prev_st != msup_pkg::ESC_STOP;
    running_base = run_entry ? 15'd0 : running;
    timeout_base = stop_entry ? 14'd0 : timeout;
    running_new  = (st_in != msup_pkg::ESC_OTHER && running_base < msup_pkg::RUN_MAX)
                   ? running_base + 15'd1 : running_base;
    timeout_new  = (st_in != msup_pkg::ESC_RUN && timeout_base < msup_pkg::TMO_MAX)
                   ? timeout_base + 14'd1 : timeout_base;
    interval     = (item.capture_time > last_cap)
                   ? {1'b0, item.capture_time} - {1'b0, last_cap}
                   : ({1'b0, msup_pkg::PULSE_MAX} - {1'b0, last_cap}) +
                     {1'b0, item.capture_time};

    silent_inc   = (silent < msup_pkg::SILENT_MAX) ? silent + 8'd1 : silent;
    tmo_prod     = {7'd0, timeout} * {14'd0, cfg.tick_ms};
    run_prod     = {7'd0, running} * {15'd0, cfg.tick_ms};
    sil_prod     = {7'd0, silent_inc} * {8'd0, cfg.tick_ms};

    pend_any     = st != msup_pkg::ESC_OTHER && pcount != '0;
    idx_inc      = idx + 1'b1;
    bad_inc      = (bad < msup_pkg::CNT_MAX) ? bad + 8'd1 : bad;
    good_inc     = (good < msup_pkg::CNT_MAX) ? good + 8'd1 : good;
    is_bad       = rd_data < {1'b0, cfg.overspeed_interval};
    if (is_bad) begin
      bad_j    = bad_inc;
      good_j   = 8'd0;
      over_hit = bad_inc >= msup_pkg::BAD_LIMIT;
    end else begin
      good_j   = good_inc;
      bad_j    = (good_inc >= msup_pkg::GOOD_LIMIT) ? 8'd0 : bad;
      over_hit = 1'b0;
    end
    under_hit     = st == msup_pkg::ESC_RUN && bad_j < msup_pkg::BAD_LIMIT && run_late &&
                    rd_data > cfg.underspeed_interval;
    stopped_final = (st == msup_pkg::ESC_STOP && speed == 16'd0) ? 1'b1 : stopped;
  end

  always_comb begin
    state_next = state;
    case (state)
      msup_pkg::ST_IDLE:   if (tick_take) state_next = msup_pkg::ST_EVAL;
      msup_pkg::ST_EVAL:   state_next = msup_pkg::ST_WIN;
      msup_pkg::ST_WIN:    state_next = msup_pkg::ST_WSUM;
      msup_pkg::ST_WSUM:   state_next = msup_pkg::ST_PREAD;
      msup_pkg::ST_PREAD:  state_next = pend_any ? msup_pkg::ST_PJUDGE : msup_pkg::ST_DONE;
      msup_pkg::ST_PJUDGE: if (idx_inc == pcount) state_next = msup_pkg::ST_DONE;
      msup_pkg::ST_DONE:   if (!res_valid || result_ready) state_next = msup_pkg::ST_IDLE;
      default:             state_next = msup_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready   = state == msup_pkg::ST_IDLE;
    win_cmd.bump = pulse_take;
    win_cmd.step = state == msup_pkg::ST_WIN && adv;
    raddr        = (state == msup_pkg::ST_PJUDGE) ? idx_inc : '0;
    res_load     = state == msup_pkg::ST_DONE && (!res_valid || result_ready);
    result       = res;
    result_valid = res_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msup_pkg::ST_IDLE;
      st        <= msup_pkg::ESC_OTHER;
      prev_st   <= msup_pkg::ESC_OTHER;
      pcount    <= '0;
      idx       <= '0;
      last_cap  <= 16'd0;
      running   <= 15'd0;
      timeout   <= 14'd0;
      silent    <= 8'd0;
      good      <= 8'd0;
      bad       <= 8'd0;
      stopped   <= 1'b1;
      adv       <= 1'b0;
      tmo_chk   <= 1'b0;
      run_late  <= 1'b0;
      sil_late  <= 1'b0;
      over      <= 1'b0;
      under     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pulse_take) begin
        if (pcount != msup_pkg::PIDX_W'(msup_pkg::PENDING_DEPTH - 1)) begin
          pcount <= pcount + 1'b1;
        end
        last_cap <= item.capture_time;
      end
      if (tick_take) begin
        st      <= st_in;
        prev_st <= st_in;
        running <= running_new;
        timeout <= timeout_new;
        over    <= 1'b0;
        under   <= 1'b0;
        if (run_entry) begin
          bad      <= 8'd0;
          good     <= 8'd0;
          pcount   <= '0;
          last_cap <= 16'd0;
        end
        if (stop_entry) begin
          stopped <= 1'b0;
        end
      end
      if (state == msup_pkg::ST_EVAL) begin
        tmo_chk  <= st != msup_pkg::ESC_RUN && tmo_prod > msup_pkg::TMO_MS;
        adv      <= st != msup_pkg::ESC_OTHER ||
                    (st != msup_pkg::ESC_RUN && tmo_prod > msup_pkg::TMO_MS);
        run_late <= run_prod > {5'd0, cfg.underspeed_delay_ms};
        sil_late <= sil_prod > {5'd0, cfg.no_pulse_limit_ms};
      end
      if (state == msup_pkg::ST_PREAD) begin
        if (pend_any) begin
          silent <= 8'd0;
          idx    <= '0;
        end else if (st == msup_pkg::ESC_RUN) begin
          silent <= silent_inc;
          if (run_late && sil_late) begin
            under   <= 1'b1;
            running <= 15'd0;
          end
        end
      end
      if (state == msup_pkg::ST_PJUDGE) begin
        bad  <= bad_j;
        good <= good_j;
        idx  <= idx_inc;
        if (over_hit || under_hit) begin
          running  <= 15'd0;
          run_late <= 1'b0;
        end
        if (over_hit) begin
          over <= 1'b1;
        end
        if (under_hit) begin
          under <= 1'b1;
        end
        if (idx_inc == pcount) begin
          pcount <= '0;
        end
      end
      if (res_load) begin
        stopped   <= stopped_final;
        res_valid <= 1'b1;
      end else if (result_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pulse_take) begin
      pend_mem[pcount] <= interval;
    end
    rd_data <= pend_mem[raddr];
    if (res_load) begin
      res.speed_pulses     <= speed;
      res.overspeed_fault  <= over;
      res.underspeed_fault <= under;
      res.timeout_fault    <= tmo_chk && speed > 16'd1;
      res.stop_done        <= stopped_final;
    end
  end

  a_pcount_bound: assert property (@(posedge clk) disable iff (rst)
    pcount <= msup_pkg::PIDX_W'(msup_pkg::PENDING_DEPTH - 1))
    else $error("pending count beyond store depth");

  a_judge_index: assert property (@(posedge clk) disable iff (rst)
    state == msup_pkg::ST_PJUDGE |-> idx < pcount)
    else $error("pending walk past last entry");

  a_judge_state: assert property (@(posedge clk) disable iff (rst)
    state == msup_pkg::ST_PJUDGE |-> st != msup_pkg::ESC_OTHER)
    else $error("pending walk outside run or stopping");

  a_tick_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    tick_take |=> !item_ready)
    else $error("tick item did not start its sequence");

  a_running_bound: assert property (@(posedge clk) disable iff (rst)
    running <= msup_pkg::RUN_MAX)
    else $error("running ticks beyond saturation");

endmodule

>>> sv/motor_speed_supervisor.sv
// ----------------------------------------------------------------------------
// motor_speed_supervisor
// Speed supervisor for one pulse sensor with an APB-style register port.
// ----------------------------------------------------------------------------
// Input channel item_valid / item_ready / item: a pulse item (kind 1) carries
// a 10 us timer capture; a tick item (kind 0) closes one system tick.
// Output channel result_valid / result_ready / result: one result per tick,
// none per pulse.
// A pulse is taken while the sequencer is idle. A tick steps through EVAL,
// WIN, WSUM, PREAD, one PJUDGE step per queued pulse interval (up to
// PENDING_DEPTH-1, walking the pending interval memory, one read per cycle)
// and DONE; the window advance costs one read and one write of slot memory.
// The result sits in an output register; the next item is taken while it
// waits. When the receiver stalls, a finished tick holds in its DONE state
// until the output register frees, and then input is taken again.
// Reset clears all counters, empties the window and the pending queue, sets
// stop_done and loads the register defaults. Write registers only while idle.
// ----------------------------------------------------------------------------
module motor_speed_supervisor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  msup_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output msup_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msup_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  msup_pkg::cfg_t     cfg;
  msup_pkg::win_cmd_t win_cmd;
  logic [15:0]        speed;
  logic [2:0]         reg_idx;
  logic               reg_wr;

  always_comb begin
    pready  = 1'b1;
    reg_idx = paddr[4:2];
    reg_wr  = psel && penable && pwrite && pready;
    case (reg_idx)
      msup_pkg::REG_TICK_MS:     prdata = {25'd0, cfg.tick_ms};
      msup_pkg::REG_OVER_IVL:    prdata = {16'd0, cfg.overspeed_interval};
      msup_pkg::REG_UNDER_IVL:   prdata = {15'd0, cfg.underspeed_interval};
      msup_pkg::REG_UNDER_DELAY: prdata = {15'd0, cfg.underspeed_delay_ms};
      msup_pkg::REG_NO_PULSE:    prdata = {22'd0, cfg.no_pulse_limit_ms};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_ms             <= msup_pkg::RST_TICK_MS;
      cfg.overspeed_interval  <= msup_pkg::RST_OVER_IVL;
      cfg.underspeed_interval <= msup_pkg::RST_UNDER_IVL;
      cfg.underspeed_delay_ms <= msup_pkg::RST_UNDER_DELAY;
      cfg.no_pulse_limit_ms   <= msup_pkg::RST_NO_PULSE;
    end else if (reg_wr) begin
      case (reg_idx)
        msup_pkg::REG_TICK_MS:     cfg.tick_ms             <= pwdata[6:0];
        msup_pkg::REG_OVER_IVL:    cfg.overspeed_interval  <= pwdata[15:0];
        msup_pkg::REG_UNDER_IVL:   cfg.underspeed_interval <= pwdata[16:0];
        msup_pkg::REG_UNDER_DELAY: cfg.underspeed_delay_ms <= pwdata[16:0];
        msup_pkg::REG_NO_PULSE:    cfg.no_pulse_limit_ms   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  msup_window u_window (
    .clk     (clk),
    .rst     (rst),
    .tick_ms (cfg.tick_ms),
    .cmd     (win_cmd),
    .speed   (speed)
  );

  msup_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .win_cmd      (win_cmd),
    .speed        (speed)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motor speed supervisor. Pulse and tick items
// go in through a valid/ready channel, with random gaps and output stalls,
// over several register settings written through the APB-style port. A
// scoreboard class keeps its own copy of the supervisor state, predicts the
// result of every accepted tick and compares each field of each result.
// ----------------------------------------------------------------------------
module tb_top;
  import msup_pkg::*;

  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          SETTLE_CYCLES = 32;
  localparam int          PHASE_ITEMS   = 130;
  localparam logic [1:0]  ESC_UNKNOWN   = 2'd3;

  class speed_scoreboard;
    cfg_t        cfg;
    bit [15:0]   window [WINDOW_SLOTS];
    bit [16:0]   pend [PENDING_DEPTH];
    bit [3:0]    pend_cnt;
    bit [15:0]   last_cap;
    bit [7:0]    slot_ticks;
    bit [15:0]   slot_pulses;
    bit [14:0]   run_ticks;
    bit [13:0]   tmo_ticks;
    bit [7:0]    silent;
    bit [7:0]    good;
    bit [7:0]    bad;
    bit          stopped;
    bit [1:0]    prev_state;
    result_t     verdicts_due [$];
    int          mismatches;

    function new();
      cfg.tick_ms             = RST_TICK_MS;
      cfg.overspeed_interval  = RST_OVER_IVL;
      cfg.underspeed_interval = RST_UNDER_IVL;
      cfg.underspeed_delay_ms = RST_UNDER_DELAY;
      cfg.no_pulse_limit_ms   = RST_NO_PULSE;
      foreach (window[i]) window[i] = '0;
      foreach (pend[i]) pend[i] = '0;
      pend_cnt    = '0;
      last_cap    = '0;
      slot_ticks  = '0;
      slot_pulses = '0;
      run_ticks   = '0;
      tmo_ticks   = '0;
      silent      = '0;
      good        = '0;
      bad         = '0;
      stopped     = 1'b1;
      prev_state  = ESC_OTHER;
      mismatches  = 0;
    endfunction

    function bit [15:0] window_total();
      int unsigned total;
      total = 0;
      foreach (window[i]) total += window[i];
      return (total > 32'hFFFF) ? 16'hFFFF : total[15:0];
    endfunction

    function bit [15:0] step_window();
      int unsigned tm;
      tm = cfg.tick_ms;
      slot_ticks = slot_ticks + 8'd1;
      if (slot_ticks * tm >= SLOT_MS) begin
        slot_ticks = '0;
        for (int i = WINDOW_SLOTS - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = slot_pulses;
        slot_pulses = '0;
      end
      return window_total();
    endfunction

    function void apply_item(item_t it);
      bit [1:0]    st;
      bit [15:0]   speed;
      bit [16:0]   iv;
      bit          measured;
      bit          over;
      bit          under;
      bit          tmo;
      int unsigned tm;
      result_t     r;
      tm = cfg.tick_ms;
      st = (it.esc_state == ESC_RUN || it.esc_state == ESC_STOP) ? it.esc_state : ESC_OTHER;
      if (it.kind == KIND_PULSE) begin
        if (st == ESC_OTHER) return;
        if (it.capture_time > last_cap)
          iv = 17'(it.capture_time - last_cap);
        else
          iv = 17'(16'hFFFF - last_cap) + 17'(it.capture_time);
        pend[pend_cnt] = iv;
        if (pend_cnt < PENDING_DEPTH - 1) pend_cnt++;
        last_cap = it.capture_time;
        if (slot_pulses != PULSE_MAX) slot_pulses++;
        return;
      end

      speed    = '0;
      measured = 1'b0;
      over     = 1'b0;
      under    = 1'b0;
      tmo      = 1'b0;
      if (st == ESC_RUN && prev_state != ESC_RUN) begin
        run_ticks = '0;
        bad       = '0;
        good      = '0;
        pend_cnt  = '0;
        last_cap  = '0;
      end else if (st == ESC_STOP && prev_state != ESC_STOP) begin
        stopped   = 1'b0;
        tmo_ticks = '0;
      end

      if (st != ESC_RUN) begin
        if (tmo_ticks < TMO_MAX) tmo_ticks++;
        if (tmo_ticks * tm > TMO_MS) begin
          speed = step_window();
          measured = 1'b1;
          if (speed > 16'd1) tmo = 1'b1;
        end
      end

      if (st != ESC_OTHER) begin
        if (run_ticks < RUN_MAX) run_ticks++;
        if (!measured) begin
          speed = step_window();
          measured = 1'b1;
        end
        if (pend_cnt != 0) begin
          silent = '0;
          for (int i = 0; i < pend_cnt; i++) begin
            iv = pend[i];
            if (iv < cfg.overspeed_interval) begin
              if (bad < CNT_MAX) bad++;
              good = '0;
              if (bad >= BAD_LIMIT) begin
                over = 1'b1;
                run_ticks = '0;
              end
            end else begin
              if (good < CNT_MAX) good++;
              if (good >= GOOD_LIMIT) bad = '0;
            end
            if (st == ESC_RUN && bad < BAD_LIMIT && run_ticks * tm > cfg.underspeed_delay_ms &&
                iv > cfg.underspeed_interval) begin
              under = 1'b1;
              run_ticks = '0;
            end
          end
          pend_cnt = '0;
        end else if (st == ESC_RUN) begin
          if (silent < SILENT_MAX) silent++;
          if (run_ticks * tm > cfg.underspeed_delay_ms && silent * tm > cfg.no_pulse_limit_ms) begin
            under = 1'b1;
            run_ticks = '0;
          end
        end
        if (st == ESC_STOP && speed == 16'd0) stopped = 1'b1;
      end

      if (!measured) speed = window_total();
      prev_state = st;
      r.speed_pulses     = speed;
      r.overspeed_fault  = over;
      r.underspeed_fault = under;
      r.timeout_fault    = tmo;
      r.stop_done        = stopped;
      verdicts_due.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_verdict(result_t got);
      result_t want;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result with no tick waiting, speed %0d", got.speed_pulses));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.speed_pulses !== want.speed_pulses)
        report_mismatch($sformatf("speed_pulses got %0d expected %0d",
                                  got.speed_pulses, want.speed_pulses));
      if (got.overspeed_fault !== want.overspeed_fault)
        report_mismatch($sformatf("overspeed_fault got %0b expected %0b",
                                  got.overspeed_fault, want.overspeed_fault));
      if (got.underspeed_fault !== want.underspeed_fault)
        report_mismatch($sformatf("underspeed_fault got %0b expected %0b",
                                  got.underspeed_fault, want.underspeed_fault));
      if (got.timeout_fault !== want.timeout_fault)
        report_mismatch($sformatf("timeout_fault got %0b expected %0b",
                                  got.timeout_fault, want.timeout_fault));
      if (got.stop_done !== want.stop_done)
        report_mismatch($sformatf("stop_done got %0b expected %0b",
                                  got.stop_done, want.stop_done));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  item_t             item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  result_t           result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  speed_scoreboard   board;
  int                stim_items;
  int                cycle_count;
  bit                calm;
  logic [15:0]       timer_now;

  motor_speed_supervisor dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) board.check_verdict(result);
      if (item_valid && item_ready) board.apply_item(item);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic item_t make_item(logic k, logic [1:0] st, logic [15:0] cap);
    item_t it;
    it.kind = k;
    it.esc_state = st;
    it.capture_time = cap;
    return it;
  endfunction

  function automatic logic [15:0] next_delta();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'd0;
      1, 2, 3: return 16'($urandom_range(1, 60));
      4, 5: return 16'(board.cfg.overspeed_interval + $urandom_range(0, 4) - 2);
      6, 7: return 16'($urandom_range(100, 20000));
      8: return 16'(board.cfg.underspeed_interval + $urandom_range(0, 4) - 2);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic drain();
    item_valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send(item_t it);
    int gap;
    if ($urandom_range(0, 299) == 0) drain();
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    if (it.kind == KIND_TICK || it.esc_state == ESC_RUN || it.esc_state == ESC_STOP)
      stim_items++;
  endtask

  task automatic pulse(logic [1:0] st);
    timer_now = timer_now + next_delta();
    send(make_item(KIND_PULSE, st, timer_now));
  endtask

  task automatic tick(logic [1:0] st);
    send(make_item(KIND_TICK, st, 16'($urandom_range(0, 65535))));
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TICK_MS:     board.cfg.tick_ms             = value[6:0];
      REG_OVER_IVL:    board.cfg.overspeed_interval  = value[15:0];
      REG_UNDER_IVL:   board.cfg.underspeed_interval = value[16:0];
      REG_UNDER_DELAY: board.cfg.underspeed_delay_ms = value[16:0];
      REG_NO_PULSE:    board.cfg.no_pulse_limit_ms   = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned tick_ms, int unsigned over, int unsigned under,
                            int unsigned delay, int unsigned no_pulse);
    drain();
    apb_write(REG_TICK_MS, tick_ms);
    apb_write(REG_OVER_IVL, over);
    apb_write(REG_UNDER_IVL, under);
    apb_write(REG_UNDER_DELAY, delay);
    apb_write(REG_NO_PULSE, no_pulse);
  endtask

  function automatic int long_span();
    return 8000 / board.cfg.tick_ms + $urandom_range(2, 20);
  endfunction

  task automatic run_episode();
    int n;
    int k;
    bit long_run;
    calm = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(5, 20))
        send(make_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       16'($urandom_range(0, 65535))));
      return;
    end
    n = $urandom_range(2, 40);
    repeat (n) begin
      k = $urandom_range(0, 19);
      k = (k < 6) ? 0 : (k < 16) ? $urandom_range(1, 2) : (k < 19) ? $urandom_range(3, 5)
                                                                  : $urandom_range(9, 13);
      repeat (k) pulse(ESC_RUN);
      tick(ESC_RUN);
    end
    // skip the stopping process now and then
    if ($urandom_range(0, 3) != 0) begin
      long_run = board.cfg.tick_ms >= 50 && $urandom_range(0, 3) == 0;
      n = long_run ? long_span() : $urandom_range(1, 25);
      repeat (n) begin
        k = long_run ? $urandom_range(0, 2) : ($urandom_range(0, 2) == 0);
        repeat (k) pulse(ESC_STOP);
        tick(ESC_STOP);
      end
    end
    long_run = board.cfg.tick_ms >= 50 && $urandom_range(0, 4) == 0;
    n = long_run ? long_span() : $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) pulse($urandom_range(0, 1) ? ESC_OTHER : ESC_UNKNOWN);
      tick($urandom_range(0, 1) ? ESC_OTHER : ESC_UNKNOWN);
    end
  endtask

  task automatic run_phase();
    int base;
    base = stim_items;
    while (stim_items - base < PHASE_ITEMS) run_episode();
  endtask

  initial begin
    forever begin
      int g;
      @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        result_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    board = new();
    stim_items = 0;
    calm = 1'b0;
    timer_now = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tick(ESC_OTHER);
    send(make_item(KIND_PULSE, ESC_OTHER, 16'd1234));
    send(make_item(KIND_PULSE, ESC_UNKNOWN, 16'hFFFF));
    send(make_item(KIND_TICK, ESC_UNKNOWN, 16'hFFFF));
    tick(ESC_RUN);
    send(make_item(KIND_PULSE, ESC_RUN, 16'h0000));
    send(make_item(KIND_PULSE, ESC_RUN, 16'hFFFF));
    send(make_item(KIND_PULSE, ESC_RUN, 16'h0001));
    for (int i = 0; i < 12; i++)
      send(make_item(KIND_PULSE, ESC_RUN, 16'(2 + 3 * i)));
    tick(ESC_RUN);
    send(make_item(KIND_PULSE, ESC_STOP, 16'd100));
    tick(ESC_STOP);
    tick(ESC_STOP);
    tick(ESC_OTHER);

    run_phase();
    set_config(100, 1000, 10000, 0, 1);
    run_phase();
    set_config(1, 65535, 1, 131071, 1023);
    run_phase();
    set_config(127, 1, 131071, 0, 1000);
    run_phase();
    set_config(0, 3000, 20000, 0, 1);
    run_phase();
    set_config(50, 500, 5000, 300, 60);
    run_phase();
    set_config($urandom_range(1, 100), $urandom_range(1, 65535), $urandom_range(1, 131071),
               $urandom_range(0, 100000), $urandom_range(1, 1000));
    run_phase();

    drain();
    if (board.mismatches == 0 && board.verdicts_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
sv/msup_pkg.sv
sv/msup_window.sv
sv/msup_ctrl.sv
sv/motor_speed_supervisor.sv
tb/sv/tb_top.sv
